[rtl/prc_pkg.sv]
package prc_pkg;

	localparam int DEB_CNT_W = 4;
	localparam int TICK_W    = 16;
	localparam int LEVEL_W   = 10;
	localparam int BLINK_W   = 5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_SWEEP = 3'd1,
		PH_BOOT  = 3'd2,
		PH_RUN   = 3'd3,
		PH_LOW   = 3'd4
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOOT_LEVEL  = 3'd0,
		REG_LEVEL_ONE   = 3'd1,
		REG_LEVEL_TWO   = 3'd2,
		REG_LEVEL_THREE = 3'd3,
		REG_LEVEL_FOUR  = 3'd4,
		REG_BOOT_TICKS  = 3'd5,
		REG_HOLD_TICKS  = 3'd6,
		REG_BLINK_TICKS = 3'd7
	} cfg_reg_t;

	localparam logic [LEVEL_W-1:0] BOOT_LEVEL_RST  = 10'd740;
	localparam logic [LEVEL_W-1:0] LEVEL_ONE_RST   = 10'd720;
	localparam logic [LEVEL_W-1:0] LEVEL_TWO_RST   = 10'd840;
	localparam logic [LEVEL_W-1:0] LEVEL_THREE_RST = 10'd879;
	localparam logic [LEVEL_W-1:0] LEVEL_FOUR_RST  = 10'd922;
	localparam logic [TICK_W-1:0]  BOOT_TICKS_RST  = 16'd500;
	localparam logic [TICK_W-1:0]  HOLD_TICKS_RST  = 16'd3000;
	localparam logic [TICK_W-1:0]  BLINK_TICKS_RST = 16'd300;

	localparam logic [7:0] DUTY_TOP = 8'd255;
	localparam logic [TICK_W-1:0] HOLD_MAX = 16'hFFFF;

	typedef struct packed {
		logic                trigger_pressed;
		logic                hv_pressed;
		logic [LEVEL_W-1:0]  throttle_sample;
		logic [LEVEL_W-1:0]  battery_sample;
	} item_t;

	typedef struct packed {
		logic [7:0] pwm_duty;
		logic       hv_drive;
		logic [3:0] led_pattern;
		logic [2:0] phase_now;
		logic       mode_now;
		logic       hv_enabled_now;
	} result_t;

	// debouncer status for one tick
	typedef struct packed {
		logic press;
		logic release_edge;
		logic stable_next;
	} deb_t;

endpackage

[rtl/prc_debounce.sv]
module prc_debounce #(
	parameter int DEBOUNCE_TICKS = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          raw,
	output prc_pkg::deb_t deb
);
	import prc_pkg::*;

	logic                 stable_q;
	logic [DEB_CNT_W-1:0] count_q;
	logic [DEB_CNT_W-1:0] count_inc;
	logic [DEB_CNT_W-1:0] count_next;
	logic                 settled;

	assign count_inc = count_q + DEB_CNT_W'(1);
	assign settled   = (raw != stable_q) && (count_inc >= DEB_CNT_W'(DEBOUNCE_TICKS));

	always_comb begin
		if (raw == stable_q || settled) begin
			count_next = '0;
		end else begin
			count_next = count_inc;
		end
		deb.press        = settled && raw;
		deb.release_edge = settled && !raw;
		deb.stable_next  = settled ? raw : stable_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= 1'b0;
			count_q  <= '0;
		end else if (en) begin
			stable_q <= deb.stable_next;
			count_q  <= count_next;
		end
	end

endmodule

[rtl/prc_batt_avg.sv]
module prc_batt_avg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic [prc_pkg::LEVEL_W-1:0]  sample,
	output logic [prc_pkg::LEVEL_W-1:0]  avg
);
	import prc_pkg::*;

	logic [LEVEL_W-1:0] window_q [3];
	logic [LEVEL_W+1:0] sum;

	// this tick's sample plus the three before it
	assign sum = {2'b00, sample} + {2'b00, window_q[0]} + {2'b00, window_q[1]}
		+ {2'b00, window_q[2]};
	assign avg = sum[LEVEL_W+1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q[0] <= '0;
			window_q[1] <= '0;
			window_q[2] <= '0;
		end else if (en) begin
			window_q[0] <= sample;
			window_q[1] <= window_q[0];
			window_q[2] <= window_q[1];
		end
	end

endmodule

[rtl/pump_run_controller.sv]
// channel  | handshake              | payload
// item     | item_valid, item_stall | item (trigger, hv, throttle, battery)
// result   | result_valid, result_stall | result (duty, hv, leds, phase, mode, enable)
// cfg      | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// an item is registered into item_s1 on transfer and processed from there into the result register,
// which loads only while it is empty or being taken; one item per cycle sustained while result_stall stays low
// the phase state machine updates all of its state together whenever an item is processed
// reset clears phase, counters, debouncers, battery window and restores register defaults
// a stalled result holds; the input register keeps taking items until it is full too
module pump_run_controller #(
	parameter int DEBOUNCE_TICKS   = 10,
	parameter int SWEEP_STEP_TICKS = 100,
	parameter int BLINK_HALVES     = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  prc_pkg::item_t                 item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output prc_pkg::result_t               result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [prc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [prc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import prc_pkg::*;

	localparam int SWEEP_END = 4 * SWEEP_STEP_TICKS;

	// configuration registers
	logic [LEVEL_W-1:0] boot_level_q, level_one_q, level_two_q, level_three_q, level_four_q;
	logic [TICK_W-1:0]  boot_ticks_q, hold_ticks_q, blink_ticks_q;

	// pipeline
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	logic    fire;
	logic    result_valid_q;
	result_t result_q;

	// controller state
	phase_t              phase_q, phase_next;
	logic                mode_q, mode_next;
	logic                hv_en_q, hv_en_next;
	logic [TICK_W-1:0]   timer_q, timer_next;
	logic [TICK_W-1:0]   hold_q, hold_next;
	logic [BLINK_W-1:0]  blink_q, blink_next;
	result_t             res_next;

	logic [TICK_W-1:0]   timer_inc, hold_inc;
	logic [BLINK_W-1:0]  blink_inc;
	logic [LEVEL_W-1:0]  avg;
	logic [1:0]          step;
	logic [3:0]          level_leds;
	deb_t                trg_deb, hv_deb;
	logic                stop;
	logic                under_volt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_level_q  <= BOOT_LEVEL_RST;
			level_one_q   <= LEVEL_ONE_RST;
			level_two_q   <= LEVEL_TWO_RST;
			level_three_q <= LEVEL_THREE_RST;
			level_four_q  <= LEVEL_FOUR_RST;
			boot_ticks_q  <= BOOT_TICKS_RST;
			hold_ticks_q  <= HOLD_TICKS_RST;
			blink_ticks_q <= BLINK_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BOOT_LEVEL:  boot_level_q  <= cfg_data[LEVEL_W-1:0];
				REG_LEVEL_ONE:   level_one_q   <= cfg_data[LEVEL_W-1:0];
				REG_LEVEL_TWO:   level_two_q   <= cfg_data[LEVEL_W-1:0];
				REG_LEVEL_THREE: level_three_q <= cfg_data[LEVEL_W-1:0];
				REG_LEVEL_FOUR:  level_four_q  <= cfg_data[LEVEL_W-1:0];
				REG_BOOT_TICKS:  boot_ticks_q  <= cfg_data[TICK_W-1:0];
				REG_HOLD_TICKS:  hold_ticks_q  <= cfg_data[TICK_W-1:0];
				REG_BLINK_TICKS: blink_ticks_q <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake and pipeline valids
	assign advance      = !result_valid_q || !result_stall;
	assign fire         = valid_s1 && advance;
	assign item_stall   = valid_s1 && !advance;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				result_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
		if (fire) begin
			result_q <= res_next;
		end
	end

	prc_debounce #(
		.DEBOUNCE_TICKS(DEBOUNCE_TICKS)
	) u_trg_deb (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (fire && phase_q != PH_SWEEP),
		.raw   (item_s1.trigger_pressed),
		.deb   (trg_deb)
	);

	prc_debounce #(
		.DEBOUNCE_TICKS(DEBOUNCE_TICKS)
	) u_hv_deb (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (fire && (phase_q == PH_BOOT || phase_q == PH_RUN)),
		.raw   (item_s1.hv_pressed),
		.deb   (hv_deb)
	);

	prc_batt_avg u_batt_avg (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (fire),
		.sample(item_s1.battery_sample),
		.avg   (avg)
	);

	assign timer_inc = timer_q + TICK_W'(1);
	assign hold_inc  = (hold_q != HOLD_MAX) ? hold_q + TICK_W'(1) : hold_q;
	assign blink_inc = blink_q + BLINK_W'(1);

	// mode 0 stops once the trigger has settled released (not on the release edge) with the raw level agreeing
	assign stop = mode_q ? trg_deb.press
		: (!trg_deb.press && !trg_deb.release_edge && !trg_deb.stable_next
			&& !item_s1.trigger_pressed);

	assign under_volt = (((phase_q == PH_RUN) || (timer_q == '0)) && (avg < boot_level_q))
		|| (avg < level_one_q);

	assign level_leds = {avg >= level_four_q, avg >= level_three_q,
		avg >= level_two_q, avg >= level_one_q};

	always_comb begin
		phase_next = phase_q;
		mode_next  = mode_q;
		hv_en_next = hv_en_q;
		timer_next = timer_q;
		hold_next  = hold_q;
		blink_next = blink_q;
		step       = 2'd0;

		unique case (phase_q)
			PH_IDLE: begin
				if (trg_deb.press) begin
					phase_next = PH_BOOT;
					hold_next  = '0;
				end else if (item_s1.hv_pressed) begin
					if (hold_inc >= hold_ticks_q) begin
						mode_next  = !mode_q;
						phase_next = PH_SWEEP;
						hold_next  = '0;
					end else begin
						hold_next = hold_inc;
					end
				end else begin
					hold_next = '0;
				end
			end
			PH_SWEEP: begin
				if (timer_inc >= TICK_W'(SWEEP_END)) begin
					phase_next = PH_IDLE;
					timer_next = '0;
				end else begin
					timer_next = timer_inc;
				end
			end
			PH_BOOT, PH_RUN: begin
				if (hv_deb.press) begin
					hv_en_next = !hv_en_q;
				end
				if (under_volt) begin
					phase_next = PH_LOW;
					timer_next = '0;
				end else if (stop) begin
					phase_next = PH_IDLE;
					timer_next = '0;
				end else if (phase_q == PH_BOOT) begin
					if (timer_inc >= boot_ticks_q) begin
						phase_next = PH_RUN;
						timer_next = '0;
					end else begin
						timer_next = timer_inc;
					end
				end
			end
			default: begin
				if (stop) begin
					phase_next = PH_IDLE;
					timer_next = '0;
					blink_next = '0;
				end else if (timer_inc >= blink_ticks_q) begin
					timer_next = '0;
					if (blink_inc >= BLINK_W'(BLINK_HALVES)) begin
						phase_next = PH_IDLE;
						blink_next = '0;
					end else begin
						blink_next = blink_inc;
					end
				end else begin
					timer_next = timer_inc;
				end
			end
		endcase

		// result shows the state after this tick
		res_next.pwm_duty       = '0;
		res_next.hv_drive       = 1'b0;
		res_next.led_pattern    = '0;
		res_next.phase_now      = phase_next;
		res_next.mode_now       = mode_next;
		res_next.hv_enabled_now = hv_en_next;
		unique case (phase_next)
			PH_SWEEP: begin
				if (timer_next >= TICK_W'(3 * SWEEP_STEP_TICKS)) begin
					step = 2'd3;
				end else if (timer_next >= TICK_W'(2 * SWEEP_STEP_TICKS)) begin
					step = 2'd2;
				end else if (timer_next >= TICK_W'(SWEEP_STEP_TICKS)) begin
					step = 2'd1;
				end
				res_next.led_pattern = mode_next ? (4'b0001 << step) : (4'b1000 >> step);
			end
			PH_BOOT, PH_RUN: begin
				res_next.pwm_duty    = DUTY_TOP - {1'b0, item_s1.throttle_sample[LEVEL_W-1:3]};
				res_next.led_pattern = level_leds;
				res_next.hv_drive    = (phase_next == PH_RUN) && hv_en_next;
			end
			PH_LOW: begin
				res_next.led_pattern = {3'b000, !blink_next[0]};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			mode_q  <= 1'b0;
			hv_en_q <= 1'b0;
			timer_q <= '0;
			hold_q  <= '0;
			blink_q <= '0;
		end else if (fire) begin
			phase_q <= phase_next;
			mode_q  <= mode_next;
			hv_en_q <= hv_en_next;
			timer_q <= timer_next;
			hold_q  <= hold_next;
			blink_q <= blink_next;
		end
	end

	// the input side only waits when a finished result is held back
	assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall))
		else $error("input stalled without a held result");

	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.hv_drive) |-> (result.phase_now == PH_RUN))
		else $error("hv drive outside run");

	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.pwm_duty != '0) |->
			(result.phase_now == PH_BOOT || result.phase_now == PH_RUN))
		else $error("pump duty outside boot or run");

	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (timer_q == '0 && blink_q == '0))
		else $error("phase timer not cleared in idle");

endmodule

[dv/testbench.sv]
import prc_pkg::*;

typedef enum {EDGE_NONE, EDGE_PRESS, EDGE_RELEASE} switch_edge_e;

typedef bit [15:0] reg_set_t [8];

class pump_tick_scoreboard;
	localparam int DEBOUNCE_LEN = 10;
	localparam int SWEEP_STEP = 100;
	localparam int BLINK_HALF_COUNT = 20;

	bit [LEVEL_W-1:0] boot_level, level_one, level_two, level_three, level_four;
	bit [TICK_W-1:0] boot_ticks, hold_ticks, blink_ticks;

	phase_t phase;
	bit trig_stable, hv_stable, mode_sel, hv_en;
	bit [DEB_CNT_W-1:0] trig_cnt, hv_cnt;
	bit [TICK_W-1:0] ph_timer, hold_cnt;
	bit [BLINK_W-1:0] blink_cnt;
	bit [LEVEL_W-1:0] bat_win [4];

	result_t awaited [$];
	int errors;

	function new();
		boot_level = BOOT_LEVEL_RST;
		level_one = LEVEL_ONE_RST;
		level_two = LEVEL_TWO_RST;
		level_three = LEVEL_THREE_RST;
		level_four = LEVEL_FOUR_RST;
		boot_ticks = BOOT_TICKS_RST;
		hold_ticks = HOLD_TICKS_RST;
		blink_ticks = BLINK_TICKS_RST;
		phase = PH_IDLE;
		trig_stable = 0;
		hv_stable = 0;
		mode_sel = 0;
		hv_en = 0;
		trig_cnt = 0;
		hv_cnt = 0;
		ph_timer = 0;
		hold_cnt = 0;
		blink_cnt = 0;
		foreach (bat_win[i]) bat_win[i] = 0;
		errors = 0;
	endfunction

	function void set_reg(cfg_reg_t idx, bit [15:0] val);
		case (idx)
			REG_BOOT_LEVEL:  boot_level = val[LEVEL_W-1:0];
			REG_LEVEL_ONE:   level_one = val[LEVEL_W-1:0];
			REG_LEVEL_TWO:   level_two = val[LEVEL_W-1:0];
			REG_LEVEL_THREE: level_three = val[LEVEL_W-1:0];
			REG_LEVEL_FOUR:  level_four = val[LEVEL_W-1:0];
			REG_BOOT_TICKS:  boot_ticks = val;
			REG_HOLD_TICKS:  hold_ticks = val;
			REG_BLINK_TICKS: blink_ticks = val;
			default: ;
		endcase
	endfunction

	function void debounce(input bit raw, inout bit stable, inout bit [DEB_CNT_W-1:0] cnt,
			output switch_edge_e ev);
		ev = EDGE_NONE;
		if (raw == stable) begin
			cnt = 0;
		end else begin
			cnt = cnt + 1'b1;
			if (cnt >= DEBOUNCE_LEN) begin
				stable = raw;
				cnt = 0;
				ev = raw ? EDGE_PRESS : EDGE_RELEASE;
			end
		end
	endfunction

	function void enter(phase_t p);
		phase = p;
		ph_timer = 0;
		blink_cnt = 0;
		hold_cnt = 0;
	endfunction

	// advance one tick and queue the output it produces
	function void note_item(item_t it);
		bit [11:0] sum;
		bit [LEVEL_W-1:0] avg;
		switch_edge_e tedge, hedge;
		bit stop;
		int step;
		result_t r;
		bat_win[3] = bat_win[2];
		bat_win[2] = bat_win[1];
		bat_win[1] = bat_win[0];
		bat_win[0] = it.battery_sample;
		sum = bat_win[0] + bat_win[1] + bat_win[2] + bat_win[3];
		avg = sum[11:2];
		tedge = EDGE_NONE;
		stop = 0;
		// trigger debouncer frozen during the mode sweep
		if (phase != PH_SWEEP) begin
			debounce(it.trigger_pressed, trig_stable, trig_cnt, tedge);
			if (mode_sel)
				stop = (tedge == EDGE_PRESS);
			else
				stop = (tedge == EDGE_NONE && !trig_stable && !it.trigger_pressed);
		end
		case (phase)
			PH_IDLE: begin
				if (tedge == EDGE_PRESS) begin
					enter(PH_BOOT);
				end else if (it.hv_pressed) begin
					if (hold_cnt != HOLD_MAX) hold_cnt = hold_cnt + 1'b1;
					if (hold_cnt >= hold_ticks) begin
						mode_sel = !mode_sel;
						enter(PH_SWEEP);
					end
				end else begin
					hold_cnt = 0;
				end
			end
			PH_SWEEP: begin
				ph_timer = ph_timer + 1'b1;
				if (ph_timer >= 4 * SWEEP_STEP) enter(PH_IDLE);
			end
			PH_BOOT, PH_RUN: begin
				debounce(it.hv_pressed, hv_stable, hv_cnt, hedge);
				if (hedge == EDGE_PRESS) hv_en = !hv_en;
				if (((phase == PH_RUN || ph_timer == 0) && avg < boot_level) || avg < level_one) begin
					enter(PH_LOW);
				end else if (stop) begin
					enter(PH_IDLE);
				end else if (phase == PH_BOOT) begin
					ph_timer = ph_timer + 1'b1;
					if (ph_timer >= boot_ticks) enter(PH_RUN);
				end
			end
			default: begin
				if (stop) begin
					enter(PH_IDLE);
				end else begin
					ph_timer = ph_timer + 1'b1;
					if (ph_timer >= blink_ticks) begin
						ph_timer = 0;
						blink_cnt = blink_cnt + 1'b1;
						if (blink_cnt >= BLINK_HALF_COUNT) enter(PH_IDLE);
					end
				end
			end
		endcase
		r = '0;
		if (phase == PH_SWEEP) begin
			step = ph_timer / SWEEP_STEP;
			if (step > 3) step = 3;
			r.led_pattern = mode_sel ? (4'b0001 << step) : (4'b1000 >> step);
		end else if (phase == PH_BOOT || phase == PH_RUN) begin
			r.pwm_duty = DUTY_TOP - 8'(it.throttle_sample >> 3);
			if (avg >= level_one) r.led_pattern[0] = 1'b1;
			if (avg >= level_two) r.led_pattern[1] = 1'b1;
			if (avg >= level_three) r.led_pattern[2] = 1'b1;
			if (avg >= level_four) r.led_pattern[3] = 1'b1;
			if (phase == PH_RUN) r.hv_drive = hv_en;
		end else if (phase == PH_LOW) begin
			r.led_pattern = blink_cnt[0] ? 4'b0000 : 4'b0001;
		end
		r.phase_now = phase;
		r.mode_now = mode_sel;
		r.hv_enabled_now = hv_en;
		awaited.push_back(r);
	endfunction

	function void compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s expected %0d got %0d", name, want, got);
			errors++;
		end
	endfunction

	function void check_result(result_t got);
		result_t want;
		if (awaited.size() == 0) begin
			$error("result transfer with no output awaited");
			errors++;
			return;
		end
		want = awaited.pop_front();
		compare_field("pwm_duty", want.pwm_duty, got.pwm_duty);
		compare_field("hv_drive", 8'(want.hv_drive), 8'(got.hv_drive));
		compare_field("led_pattern", 8'(want.led_pattern), 8'(got.led_pattern));
		compare_field("phase_now", 8'(want.phase_now), 8'(got.phase_now));
		compare_field("mode_now", 8'(want.mode_now), 8'(got.mode_now));
		compare_field("hv_enabled_now", 8'(want.hv_enabled_now), 8'(got.hv_enabled_now));
	endfunction

	function int pending();
		return awaited.size();
	endfunction
endclass

module testbench;
	localparam int QUIET_LIMIT = 4000;
	localparam int SQUEEZE_CYCLES = 300;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	item_t item_word;
	logic result_valid;
	logic result_stall;
	result_t result_word;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pump_tick_scoreboard sb;
	bit tx_gaps, rx_gaps, squeeze_req;
	bit want_trig, want_hv;
	int bat_target, run_left;
	int quiet;

	pump_run_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item_word),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall) sb.note_item(item_word);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) sb.check_result(result_word);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// result side: random stall bursts, plus one long hold-off on request
	initial begin
		int held;
		result_stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (squeeze_req) begin
				squeeze_req = 0;
				result_stall <= 1;
				for (held = 0; held < SQUEEZE_CYCLES; held++) @(negedge clk);
				result_stall <= 0;
			end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
				result_stall <= 1;
				repeat ($urandom_range(1, 11)) @(negedge clk);
				result_stall <= 0;
			end
		end
	end

	task automatic send_item(item_t it);
		if (tx_gaps && $urandom_range(0, 9) == 0) begin
			item_valid <= 0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		item_word <= it;
		item_valid <= 1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic item_t make_item(bit trg, bit hv, int thr, int bat);
		item_t it;
		it.trigger_pressed = trg;
		it.hv_pressed = hv;
		it.throttle_sample = LEVEL_W'(thr);
		it.battery_sample = LEVEL_W'(bat);
		return it;
	endfunction

	function automatic int pick_battery();
		int pivot;
		case ($urandom_range(0, 6))
			0: return $urandom_range(0, 1023);
			1: pivot = int'(sb.boot_level);
			2: pivot = int'(sb.level_one);
			3: pivot = int'(sb.level_two);
			4: pivot = int'(sb.level_three);
			5: pivot = int'(sb.level_four);
			default: return $urandom_range(0, 1) ? 1023 : 0;
		endcase
		return pivot + int'($urandom_range(0, 16)) - 8;
	endfunction

	// switch levels held for runs long enough to debounce, with glitches and short runs
	task automatic run_ticks(int n);
		int b;
		item_t it;
		repeat (n) begin
			if (run_left == 0) begin
				run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : $urandom_range(10, 70);
				if ($urandom_range(0, 2) == 0) want_trig = !want_trig;
				if ($urandom_range(0, 1) == 0) want_hv = !want_hv;
				if ($urandom_range(0, 3) == 0) bat_target = pick_battery();
			end
			run_left--;
			b = bat_target + int'($urandom_range(0, 6)) - 3;
			if (b < 0) b = 0;
			if (b > 1023) b = 1023;
			it = make_item(want_trig ^ ($urandom_range(0, 29) == 0),
				want_hv ^ ($urandom_range(0, 29) == 0), int'($urandom_range(0, 1023)), b);
			send_item(it);
		end
	endtask

	task automatic settle();
		item_valid <= 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, bit [15:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic run_phase(reg_set_t s, bit txg, bit rxg, int n);
		cfg_reg_t r;
		settle();
		r = REG_BOOT_LEVEL;
		repeat (8) begin
			write_reg(r, s[r]);
			r = r.next();
		end
		cfg_valid <= 0;
		tx_gaps = txg;
		rx_gaps = rxg;
		run_ticks(n);
	endtask

	function automatic reg_set_t random_set();
		reg_set_t s;
		int l1;
		l1 = $urandom_range(150, 700);
		s[REG_LEVEL_ONE] = 16'(l1);
		s[REG_LEVEL_TWO] = s[REG_LEVEL_ONE] + 16'($urandom_range(0, 110));
		s[REG_LEVEL_THREE] = s[REG_LEVEL_TWO] + 16'($urandom_range(0, 100));
		s[REG_LEVEL_FOUR] = s[REG_LEVEL_THREE] + 16'($urandom_range(0, 100));
		s[REG_BOOT_LEVEL] = 16'(l1 + int'($urandom_range(0, 120)) - 60);
		s[REG_BOOT_TICKS] = 16'($urandom_range(1, 40));
		s[REG_HOLD_TICKS] = 16'($urandom_range(10, 150));
		s[REG_BLINK_TICKS] = 16'($urandom_range(1, 8));
		return s;
	endfunction

	initial begin
		reg_set_t s;
		int i;
		sb = new();
		arst_n = 0;
		item_valid = 0;
		item_word = '0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		tx_gaps = 1;
		rx_gaps = 1;
		squeeze_req = 0;
		want_trig = 0;
		want_hv = 0;
		bat_target = 1023;
		run_left = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset settings: idle, a trigger glitch, a debounced press into boot,
		// hv press in boot, then a battery collapse into low battery
		repeat (3) send_item(make_item(0, 0, 0, 1023));
		repeat (5) send_item(make_item(1, 0, 1023, 1023));
		send_item(make_item(0, 1, 0, 1023));
		for (i = 0; i < 10; i++) send_item(make_item(1, 0, i * 113, 1023));
		send_item(make_item(1, 1, 1023, 1023));
		send_item(make_item(1, 1, 7, 1023));
		repeat (4) send_item(make_item(1, 0, 0, 0));

		s[REG_BOOT_LEVEL] = 16'(BOOT_LEVEL_RST);
		s[REG_LEVEL_ONE] = 16'(LEVEL_ONE_RST);
		s[REG_LEVEL_TWO] = 16'(LEVEL_TWO_RST);
		s[REG_LEVEL_THREE] = 16'(LEVEL_THREE_RST);
		s[REG_LEVEL_FOUR] = 16'(LEVEL_FOUR_RST);
		s[REG_BOOT_TICKS] = 20;
		s[REG_HOLD_TICKS] = 60;
		s[REG_BLINK_TICKS] = 3;
		run_phase(s, 1, 1, 250);

		// lowest extremes: nothing ever low, every count reached at once
		foreach (s[k]) s[k] = 0;
		s[REG_BOOT_TICKS] = 1;
		s[REG_HOLD_TICKS] = 1;
		s[REG_BLINK_TICKS] = 1;
		run_phase(s, 0, 1, 200);

		// highest extremes
		s[REG_BOOT_LEVEL] = 1023;
		s[REG_LEVEL_ONE] = 1023;
		s[REG_LEVEL_TWO] = 1023;
		s[REG_LEVEL_THREE] = 1023;
		s[REG_LEVEL_FOUR] = 1023;
		s[REG_BOOT_TICKS] = 16'hFFFF;
		s[REG_HOLD_TICKS] = 16'hFFFF;
		s[REG_BLINK_TICKS] = 16'hFFFF;
		run_phase(s, 1, 0, 150);

		// long result hold-off while items keep coming
		run_phase(random_set(), 1, 1, 120);
		squeeze_req = 1;
		run_ticks(130);

		repeat (3) run_phase(random_set(), 1, 1, 250);
		run_phase(random_set(), 0, 0, 250);

		settle();
		repeat (4) @(posedge clk);
		if (sb.errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end
endmodule

[sim.f]
rtl/prc_pkg.sv
rtl/prc_debounce.sv
rtl/prc_batt_avg.sv
rtl/pump_run_controller.sv
dv/testbench.sv
